// ===== rtl/orbital_position_distance_core_assert.svh =====
// Assertion macros shared by the orbital position distance RTL.
`ifndef ORBITAL_POSITION_DISTANCE_CORE_ASSERT_SVH
`define ORBITAL_POSITION_DISTANCE_CORE_ASSERT_SVH
`ifndef SYNTH
`define OPD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("opd assertion failed");
`define OPD_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("opd forbidden condition");
`else
`define OPD_ASSERT(label, prop)
`define OPD_NEVER(label, cond)
`endif
`endif

// ===== rtl/opd_pkg.sv =====
// Constants, types and the arctangent table of the orbital position distance core.
package opd_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int NIT = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;

	localparam int IDW  = 16;
	localparam int CW   = 24;
	localparam int RDW  = 22;
	localparam int AW   = 16;
	localparam int DW   = 25;
	localparam int XW   = 40;
	localparam int ZW   = 34;
	localparam int GW   = 30;
	localparam int PW   = RDW + GW;
	localparam int SQW  = 2 * DW;
	localparam int RTW  = SQW / 2;
	localparam int RMW  = RTW + 2;

	localparam logic [GW-1:0] GAIN_Q30 = 30'd652032874;
	localparam logic signed [AW:0] QUARTER = 17'sd16384;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 flip;
	} rot_t;

	typedef struct packed {
		rot_t                 a;
		rot_t                 b;
		logic                 same;
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
	} cord_t;

	typedef struct packed {
		logic [SQW-1:0] v;
		logic [RMW-1:0] rem;
		logic [RTW-1:0] root;
		logic           same;
	} sq_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic signed [ZW-1:0] atan_turn(input int unsigned i);
		logic signed [ZW-1:0] r;
		case (i)
			0:  r = 34'sd536870912;
			1:  r = 34'sd316933406;
			2:  r = 34'sd167458907;
			3:  r = 34'sd85004756;
			4:  r = 34'sd42667331;
			5:  r = 34'sd21354465;
			6:  r = 34'sd10679838;
			7:  r = 34'sd5340245;
			8:  r = 34'sd2670163;
			9:  r = 34'sd1335087;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41722;
			15: r = 34'sd20861;
			16: r = 34'sd10430;
			17: r = 34'sd5215;
			18: r = 34'sd2608;
			19: r = 34'sd1304;
			20: r = 34'sd652;
			21: r = 34'sd326;
			22: r = 34'sd163;
			23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/opd_if.sv =====
// Valid/ready channel interfaces for location pairs and distance results.
interface opd_req_if;
	logic                              valid;
	logic                              ready;
	logic        [opd_pkg::IDW-1:0]    first_system_id;
	logic        [opd_pkg::IDW-1:0]    second_system_id;
	logic signed [opd_pkg::CW-1:0]     first_system_x;
	logic signed [opd_pkg::CW-1:0]     first_system_y;
	logic signed [opd_pkg::CW-1:0]     second_system_x;
	logic signed [opd_pkg::CW-1:0]     second_system_y;
	logic        [opd_pkg::RDW-1:0]    first_orbit_radius;
	logic        [opd_pkg::AW-1:0]     first_orbit_angle;
	logic        [opd_pkg::RDW-1:0]    second_orbit_radius;
	logic        [opd_pkg::AW-1:0]     second_orbit_angle;

	modport source (output valid, first_system_id, second_system_id, first_system_x,
		first_system_y, second_system_x, second_system_y, first_orbit_radius,
		first_orbit_angle, second_orbit_radius, second_orbit_angle, input ready);
	modport sink (input valid, first_system_id, second_system_id, first_system_x,
		first_system_y, second_system_x, second_system_y, first_orbit_radius,
		first_orbit_angle, second_orbit_radius, second_orbit_angle, output ready);
endinterface

interface opd_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [opd_pkg::DW-1:0]       distance;
	logic                         same_system;

	modport source (output valid, distance, same_system, input ready);
	modport sink (input valid, distance, same_system, output ready);
endinterface

// ===== rtl/orbital_position_distance_core.sv =====
// Top level: pipelined CORDIC orbit conversion and Euclidean distance.
//
// Usage:
//   req carries one pair of locations per transaction (valid/ready).
//   rsp returns one distance and the same_system flag per transaction.
//   Equal system ids select the orbit positions, which go through a CORDIC
//   rotation of one stage per iteration; otherwise the system coordinates
//   are used. The distance is the floor of the square root, one result bit
//   per stage of a restoring square root pipeline.
// Pipeline: an input stage, the CORDIC stages, a difference, a square and a sum
//   stage, then the 25 square root stages.
// Throughput: one transaction per cycle while rsp is taken.
// Reset: arst_n clears all stage valid bits; the pipeline comes up empty.
// Stall: when rsp.valid is high and rsp.ready low the whole pipeline holds,
//   req.ready drops, and nothing is lost or repeated. req.ready stays high
//   whenever the output stage is empty or being taken.
`include "orbital_position_distance_core_assert.svh"

module orbital_position_distance_core (
	input  logic   clk,
	input  logic   arst_n,
	opd_req_if.sink   req,
	opd_rsp_if.source rsp
);

	localparam int N = opd_pkg::NIT;

	logic ce;

	// one CORDIC iteration on a rotation vector
	function automatic opd_pkg::rot_t rot_step(input opd_pkg::rot_t r, input int unsigned k);
		opd_pkg::rot_t        o;
		logic signed [opd_pkg::XW-1:0] xs;
		logic signed [opd_pkg::XW-1:0] ys;
		xs = r.x >>> k;
		ys = r.y >>> k;
		o = r;
		if (r.z >= 0) begin
			o.x = r.x - ys;
			o.y = r.y + xs;
			o.z = r.z - opd_pkg::atan_turn(k);
		end else begin
			o.x = r.x + ys;
			o.y = r.y - xs;
			o.z = r.z + opd_pkg::atan_turn(k);
		end
		return o;
	endfunction

	// fold the angle into the right half plane and scale the radius by the gain
	function automatic opd_pkg::rot_t rot_init(input logic [opd_pkg::RDW-1:0] rad,
			input logic [opd_pkg::AW-1:0] ang);
		opd_pkg::rot_t                 o;
		logic signed [opd_pkg::AW:0]   s;
		logic [opd_pkg::AW-1:0]        a;
		logic [opd_pkg::PW-1:0]        p;
		s = {ang[opd_pkg::AW-1], ang};
		o.flip = (s > opd_pkg::QUARTER) || (s < -opd_pkg::QUARTER);
		a = o.flip ? {~ang[opd_pkg::AW-1], ang[opd_pkg::AW-2:0]} : ang;
		o.z = {{(opd_pkg::ZW-opd_pkg::AW-16){a[opd_pkg::AW-1]}}, a, 16'd0};
		p = opd_pkg::PW'(rad) * opd_pkg::PW'(opd_pkg::GAIN_Q30);
		o.x = opd_pkg::XW'(p[opd_pkg::PW-1:14]);
		o.y = '0;
		return o;
	endfunction

	// reduce a rotated vector to Q8 coordinates
	function automatic logic signed [opd_pkg::CW-1:0] rot_out(
			input logic signed [opd_pkg::XW-1:0] v, input logic flip);
		logic signed [opd_pkg::CW-1:0] t;
		t = v[opd_pkg::CW+15:16];
		return flip ? -t : t;
	endfunction

	// absolute difference of two coordinates
	function automatic logic [opd_pkg::DW-1:0] abs_diff(
			input logic signed [opd_pkg::CW-1:0] a, input logic signed [opd_pkg::CW-1:0] b);
		logic signed [opd_pkg::DW-1:0] d;
		d = {b[opd_pkg::CW-1], b} - {a[opd_pkg::CW-1], a};
		return d[opd_pkg::DW-1] ? opd_pkg::DW'(-d) : opd_pkg::DW'(d);
	endfunction

	// one restoring square root step
	function automatic opd_pkg::sq_t sq_step(input opd_pkg::sq_t s);
		opd_pkg::sq_t              o;
		logic [opd_pkg::RMW:0]     t;
		logic [opd_pkg::RMW:0]     trial;
		t = {s.rem[opd_pkg::RMW-2:0], s.v[opd_pkg::SQW-1:opd_pkg::SQW-2]};
		trial = {1'b0, s.root, 2'b01};
		o = s;
		o.v = {s.v[opd_pkg::SQW-3:0], 2'b00};
		if (t >= trial) begin
			o.rem = opd_pkg::RMW'(t - trial);
			o.root = {s.root[opd_pkg::RTW-2:0], 1'b1};
		end else begin
			o.rem = opd_pkg::RMW'(t);
			o.root = {s.root[opd_pkg::RTW-2:0], 1'b0};
		end
		return o;
	endfunction

	opd_pkg::cord_t cord_s [0:N];
	logic           cord_v_s [0:N];

	logic [opd_pkg::DW-1:0]  dx_s3, dy_s3;
	logic                    same_s3, v_s3;
	logic [opd_pkg::SQW-1:0] sqx_s4, sqy_s4;
	logic                    same_s4, v_s4;

	opd_pkg::sq_t sq_s [0:opd_pkg::RTW];
	logic         sq_v_s [0:opd_pkg::RTW];

	// advance the whole pipeline unless the output transaction stalls
	assign ce = !rsp.valid || rsp.ready;
	assign req.ready = ce;

	// prepare start vectors and pass the system coordinates along
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cord_v_s[0] <= 1'b0;
		end else if (ce) begin
			cord_v_s[0] <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			cord_s[0].a    <= rot_init(req.first_orbit_radius, req.first_orbit_angle);
			cord_s[0].b    <= rot_init(req.second_orbit_radius, req.second_orbit_angle);
			cord_s[0].same <= (req.first_system_id == req.second_system_id);
			cord_s[0].ax   <= req.first_system_x;
			cord_s[0].ay   <= req.first_system_y;
			cord_s[0].bx   <= req.second_system_x;
			cord_s[0].by   <= req.second_system_y;
		end
	end

	// rotate, one iteration per stage
	for (genvar k = 0; k < N; k++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cord_v_s[k+1] <= 1'b0;
			end else if (ce) begin
				cord_v_s[k+1] <= cord_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				cord_s[k+1].a    <= rot_step(cord_s[k].a, k);
				cord_s[k+1].b    <= rot_step(cord_s[k].b, k);
				cord_s[k+1].same <= cord_s[k].same;
				cord_s[k+1].ax   <= cord_s[k].ax;
				cord_s[k+1].ay   <= cord_s[k].ay;
				cord_s[k+1].bx   <= cord_s[k].bx;
				cord_s[k+1].by   <= cord_s[k].by;
			end
		end
	end

	// select the point pair, take absolute differences and square them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (ce) begin
			v_s3 <= cord_v_s[N];
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			if (cord_s[N].same) begin
				dx_s3 <= abs_diff(rot_out(cord_s[N].a.x, cord_s[N].a.flip),
					rot_out(cord_s[N].b.x, cord_s[N].b.flip));
				dy_s3 <= abs_diff(rot_out(cord_s[N].a.y, cord_s[N].a.flip),
					rot_out(cord_s[N].b.y, cord_s[N].b.flip));
			end else begin
				dx_s3 <= abs_diff(cord_s[N].ax, cord_s[N].bx);
				dy_s3 <= abs_diff(cord_s[N].ay, cord_s[N].by);
			end
			same_s3 <= cord_s[N].same;
			sqx_s4  <= opd_pkg::SQW'(dx_s3) * opd_pkg::SQW'(dx_s3);
			sqy_s4  <= opd_pkg::SQW'(dy_s3) * opd_pkg::SQW'(dy_s3);
			same_s4 <= same_s3;
		end
	end

	// sum the squares into the square root input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (ce) begin
			sq_v_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sq_s[0].v    <= sqx_s4 + sqy_s4;
			sq_s[0].rem  <= '0;
			sq_s[0].root <= '0;
			sq_s[0].same <= same_s4;
		end
	end

	// extract one root bit per stage
	for (genvar k = 0; k < opd_pkg::RTW; k++) begin : g_sqrt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (ce) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				sq_s[k+1] <= sq_step(sq_s[k]);
			end
		end
	end

	assign rsp.valid       = sq_v_s[opd_pkg::RTW];
	assign rsp.distance    = sq_s[opd_pkg::RTW].root;
	assign rsp.same_system = sq_s[opd_pkg::RTW].same;

	// the input is refused only while a result is held
	`OPD_ASSERT(a_ready_stall, !req.ready |-> (rsp.valid && !rsp.ready))
	// an accepted transaction enters the first stage
	`OPD_ASSERT(a_enter, (req.valid && req.ready) |=> cord_v_s[0])
	// a held result keeps its stage valid and its root
	`OPD_ASSERT(a_hold, (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.distance)))
	// the difference stage advances into the square stage
	`OPD_ASSERT(a_diff_adv, (ce && v_s3) |=> v_s4)

endmodule

// ===== sim/tb.sv =====
// Testbench for the orbital position distance core: directed and random location pairs.
`timescale 1ns / 100ps

module tb;

	localparam int LATENCY   = 1 + opd_pkg::NIT + 3 + 25;
	localparam int IDLE_LIMIT = 5000;

	typedef struct packed {
		logic        [opd_pkg::IDW-1:0] id_a;
		logic        [opd_pkg::IDW-1:0] id_b;
		logic signed [opd_pkg::CW-1:0]  ax;
		logic signed [opd_pkg::CW-1:0]  ay;
		logic signed [opd_pkg::CW-1:0]  bx;
		logic signed [opd_pkg::CW-1:0]  by;
		logic        [opd_pkg::RDW-1:0] ra;
		logic        [opd_pkg::AW-1:0]  ta;
		logic        [opd_pkg::RDW-1:0] rb;
		logic        [opd_pkg::AW-1:0]  tb_ang;
	} loc_pair_t;

	typedef struct packed {
		logic [opd_pkg::DW-1:0] distance;
		logic                   same_system;
	} dist_t;

	logic clk;
	logic arst_n;
	opd_req_if req ();
	opd_rsp_if rsp ();

	dist_t expected_dist_q[$];
	int    mismatch_cnt;
	int    idle_cycles;
	bit    hold_off;
	bit    timed_out;

	orbital_position_distance_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint atan_tbl(input int i);
		longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
			20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		return t[i];
	endfunction

	// Rotate one orbit into Cartesian Q8 coordinates
	function automatic void orbit_xy(input logic [opd_pkg::RDW-1:0] r,
		input logic [opd_pkg::AW-1:0] ang, output longint ox, output longint oy);
		longint x, y, z, xs, ys, s;
		bit flip;
		s = longint'($signed(ang));
		flip = 1'b0;
		if (s > 16384 || s < -16384) begin
			s = longint'($signed(ang ^ 16'h8000));
			flip = 1'b1;
		end
		z = s * 65536;
		x = (longint'(r) * 64'sd652032874) >>> 14;
		y = 0;
		for (int i = 0; i < opd_pkg::NIT; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(atan_tbl(i));
			end else begin
				x += ys; y -= xs; z += longint'(atan_tbl(i));
			end
		end
		x = x >>> 16;
		y = y >>> 16;
		ox = flip ? -x : x;
		oy = flip ? -y : y;
	endfunction

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else
				root >>= 1;
			bitv >>= 2;
		end
		return root;
	endfunction

	// Compute the expected distance for one location pair
	function automatic dist_t predict_distance(input loc_pair_t p);
		longint ax, ay, bx, by, dx, dy;
		longint unsigned root;
		dist_t d;
		d.same_system = (p.id_a == p.id_b);
		if (d.same_system) begin
			orbit_xy(p.ra, p.ta, ax, ay);
			orbit_xy(p.rb, p.tb_ang, bx, by);
		end else begin
			ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
		end
		dx = bx - ax;
		dy = by - ay;
		root = floor_root(longint'(dx * dx) + longint'(dy * dy));
		d.distance = (root > 64'h1FFFFFF) ? '1 : root[opd_pkg::DW-1:0];
		return d;
	endfunction

	task automatic report(input string what, input logic [opd_pkg::DW-1:0] got,
		input logic [opd_pkg::DW-1:0] exp);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $time);
		mismatch_cnt++;
	endtask

	// Offer one transaction after a random gap and wait for acceptance
	task automatic send_pair(input loc_pair_t p);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid              <= 1'b1;
		req.first_system_id    <= p.id_a;
		req.second_system_id   <= p.id_b;
		req.first_system_x     <= p.ax;
		req.first_system_y     <= p.ay;
		req.second_system_x    <= p.bx;
		req.second_system_y    <= p.by;
		req.first_orbit_radius <= p.ra;
		req.first_orbit_angle  <= p.ta;
		req.second_orbit_radius <= p.rb;
		req.second_orbit_angle <= p.tb_ang;
		do @(posedge clk); while (!req.ready);
		expected_dist_q = {expected_dist_q, predict_distance(p)};
	endtask

	function automatic loc_pair_t random_pair(input bit same);
		loc_pair_t p;
		logic [223:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		p = raw[$bits(loc_pair_t)-1:0];
		if (same) p.id_b = p.id_a;
		else if (p.id_a == p.id_b) p.id_b = ~p.id_a;
		return p;
	endfunction

	task automatic test_coordinate_extremes();
		loc_pair_t p;
		logic signed [opd_pkg::CW-1:0] ext[4] = '{24'sh800000, 24'sh7FFFFF, 24'sd0, -24'sd1};
		foreach (ext[i]) begin
			p = random_pair(1'b0);
			p.ax = ext[i]; p.ay = ext[i]; p.bx = ext[3-i]; p.by = ext[3-i];
			send_pair(p);
		end
		p = random_pair(1'b0);
		p.id_a = 16'hFFFF; p.id_b = 16'h0000;
		send_pair(p);
	endtask

	task automatic test_orbit_extremes();
		loc_pair_t p;
		logic [opd_pkg::AW-1:0] angs[10] = '{16'h0000, 16'h4000, 16'h4001, 16'hC000, 16'hBFFF,
			16'h8000, 16'h7FFF, 16'hFFFF, 16'h2000, 16'hE000};
		foreach (angs[i]) begin
			p = random_pair(1'b1);
			p.ra = (i % 2) ? '1 : 22'd256;
			p.ta = angs[i];
			p.rb = '1;
			p.tb_ang = angs[9-i] ^ 16'h8000;
			send_pair(p);
		end
		p = random_pair(1'b1);
		p.id_a = 16'hFFFF; p.id_b = 16'hFFFF; p.ra = '0; p.rb = '0;
		send_pair(p);
	endtask

	task automatic test_random_pairs(input int n);
		loc_pair_t p;
		for (int i = 0; i < n; i++) begin
			p = random_pair(1'($urandom_range(0, 1)));
			if ($urandom_range(0, 3) == 0) p.ra = opd_pkg::RDW'($urandom_range(0, 4096));
			send_pair(p);
		end
	endtask

	// Hold the receiver off while the sender keeps offering
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			test_random_pairs(80);
			begin
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
		join
	endtask

	// Drive the receiver ready with random stalls
	initial begin
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				rsp.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 0;
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		dist_t exp;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_dist_q.size() == 0) begin
				report("unexpected result", rsp.distance, '0);
			end else begin
				exp = expected_dist_q.pop_front();
				if (rsp.distance !== exp.distance)
					report("distance", rsp.distance, exp.distance);
				if (rsp.same_system !== exp.same_system)
					report("same_system", opd_pkg::DW'(rsp.same_system),
						opd_pkg::DW'(exp.same_system));
			end
		end
	end

	// Count cycles with no transaction on either side
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("[orbital_position_distance_core] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		hold_off = 1'b0;
		req.valid <= 1'b0;
		{req.first_system_id, req.second_system_id, req.first_system_x, req.first_system_y,
			req.second_system_x, req.second_system_y, req.first_orbit_radius,
			req.first_orbit_angle, req.second_orbit_radius, req.second_orbit_angle} <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_coordinate_extremes();
		test_orbit_extremes();
		test_random_pairs(900);
		test_backpressure();
		test_random_pairs(900);
		req.valid <= 1'b0;
		while (expected_dist_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("[orbital_position_distance_core] OK");
		else
			$display("[orbital_position_distance_core] ERROR");
		$finish;
	end
endmodule
